>>> rtl/palette_index_pair_encoder_core_macros.svh
// assertion macros for the palette index pair encoder
`ifndef PALETTE_INDEX_PAIR_ENCODER_CORE_MACROS_SVH
`define PALETTE_INDEX_PAIR_ENCODER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PIPE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PIPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pipe_pkg.sv
// shared types, constants and the digit decoder of the palette index pair encoder
package pipe_pkg;

  localparam int unsigned KEY_W            = 5;
  localparam logic [4:0]  KEY_INVALID      = 5'd16;
  localparam int unsigned PALETTE_SIZE_DEF = 16;
  localparam int unsigned DUMP_ENTRIES_DEF = 8;
  localparam logic [7:0]  MARKER_RESET     = 8'd36;
  localparam logic [7:0]  OFFSET_RESET     = 8'd35;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [0:0]  REG_MARKER = 1'b0;
  localparam logic [0:0]  REG_OFFSET = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_kind;
    logic       last;
    logic       bad_digit;
    logic       palette_full;
    logic [4:0] colours_used;
  } out_item_t;

  // hex character to key, anything else gives the invalid key
  function automatic logic [4:0] digit_key(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        t = c - 8'h30;
        return t[4:0];
      end
      if (c >= 8'h41 && c <= 8'h46) begin
        t = c - 8'h41 + 8'd10;
        return t[4:0];
      end
      if (c >= 8'h61 && c <= 8'h66) begin
        t = c - 8'h61 + 8'd10;
        return t[4:0];
      end
      return KEY_INVALID;
    end
  endfunction

endpackage

>>> rtl/pipe_palette.sv
// palette key store with a single read port and an append port
module pipe_palette #(
  parameter int unsigned PALETTE_SIZE = pipe_pkg::PALETTE_SIZE_DEF,
  parameter int unsigned SW           = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [SW-1:0]                     rd_idx_i,
  output logic [pipe_pkg::KEY_W-1:0]        rd_key_o,
  input  logic                              append_i,
  input  logic [pipe_pkg::KEY_W-1:0]        key_i,
  output logic [$clog2(PALETTE_SIZE+1)-1:0] count_o
);

  localparam int unsigned AW    = $clog2(PALETTE_SIZE);
  localparam int unsigned CNT_W = $clog2(PALETTE_SIZE + 1);

  logic [pipe_pkg::KEY_W-1:0] keys_q [PALETTE_SIZE];
  logic [CNT_W-1:0]           count_q;

  // read, entries past the store read as key zero
  always_comb begin
    rd_key_o = '0;
    if (rd_idx_i < SW'(PALETTE_SIZE)) begin
      rd_key_o = keys_q[rd_idx_i[AW-1:0]];
    end
  end

  // append a new key at the fill position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        keys_q[i] <= '0;
      end
    end else if (append_i && (count_q < CNT_W'(PALETTE_SIZE))) begin
      keys_q[count_q[AW-1:0]] <= key_i;
      count_q                 <= count_q + CNT_W'(1);
    end
  end

  assign count_o = count_q;

endmodule

>>> rtl/palette_index_pair_encoder_core.sv
// palette index pair encoder: a colour digit is accepted, then the shared key comparator
// scans the palette entries in use until a hit or the fill count; a pair then emits one beat,
// a character outside a pair is taken in idle alone, and a dump emits DUMP_ENTRIES beats.
// one item is worked at a time; the palette scan and output back-pressure hold the input.
// reset (async, active low) clears the palette, the fill count, the digit phase and the
// first-digit state and loads marker 36 and offset 35; no clearing pass is needed.
`include "palette_index_pair_encoder_core_macros.svh"

module palette_index_pair_encoder_core #(
  parameter int unsigned PALETTE_SIZE = pipe_pkg::PALETTE_SIZE_DEF,
  parameter int unsigned DUMP_ENTRIES = pipe_pkg::DUMP_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pipe_pkg::in_item_t             in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pipe_pkg::out_item_t            out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pipe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(PALETTE_SIZE + 1);
  localparam int unsigned DW    = $clog2(DUMP_ENTRIES + 1);
  localparam int unsigned SW    = (CNT_W > DW) ? CNT_W : DW;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  // digit phases
  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [1:0]             phase_q, phase_d;
  logic [3:0]             first_idx_q, first_idx_d;
  logic                   first_bad_q, first_bad_d;
  logic                   first_full_q, first_full_d;
  logic [4:0]             key_q, key_d;
  logic [SW-1:0]          scan_q, scan_d;
  logic [3:0]             pair_idx_q, pair_idx_d;
  logic                   pair_bad_q, pair_bad_d;
  logic                   pair_full_q, pair_full_d;
  logic [7:0]             marker_q, offset_q;
  logic                   out_valid_q, out_valid_d;
  pipe_pkg::out_item_t    out_q, out_d;

  logic                   in_fire, can_load, load;
  logic [4:0]             rd_key;
  logic [CNT_W-1:0]       pal_count;
  logic [SW-1:0]          cnt_ext;
  logic                   append;
  logic                   hit, miss_end, full;
  logic [3:0]             idx;
  logic [7:0]             dump_add;

  pipe_palette #(
    .PALETTE_SIZE(PALETTE_SIZE),
    .SW          (SW)
  ) u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_idx_i(scan_q),
    .rd_key_o(rd_key),
    .append_i(append),
    .key_i   (key_q),
    .count_o (pal_count)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign can_load    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign cnt_ext     = SW'(pal_count);

  // shared comparator: one palette entry per cycle
  always_comb begin
    hit      = (state_q == S_LOOK) && (scan_q < cnt_ext) && (rd_key == key_q);
    miss_end = (state_q == S_LOOK) && (scan_q >= cnt_ext);
    full     = miss_end && (pal_count >= CNT_W'(PALETTE_SIZE));
    append   = miss_end && !full;
    idx      = 4'(scan_q);
    if (miss_end) begin
      idx = full ? 4'(PALETTE_SIZE - 1) : 4'(pal_count);
    end
  end

  // invalid key on dump counts as minus one
  assign dump_add = rd_key[4] ? 8'hFF : {4'b0000, rd_key[3:0]};

  // sequencer
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    first_idx_d  = first_idx_q;
    first_bad_d  = first_bad_q;
    first_full_d = first_full_q;
    key_d        = key_q;
    scan_d       = scan_q;
    pair_idx_d   = pair_idx_q;
    pair_bad_d   = pair_bad_q;
    pair_full_d  = pair_full_q;
    load         = 1'b0;
    out_d        = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.mode) begin
            state_d = S_DUMP;
            scan_d  = '0;
          end else if (phase_q == PH_FIRST || phase_q == PH_SECOND) begin
            state_d = S_LOOK;
            scan_d  = '0;
            key_d   = pipe_pkg::digit_key(in_i.char_in);
          end else begin
            phase_d = (in_i.char_in == marker_q) ? PH_FIRST : PH_WAIT;
          end
        end
      end
      S_LOOK: begin
        if (hit || miss_end) begin
          if (phase_q == PH_FIRST) begin
            first_idx_d  = idx;
            first_bad_d  = key_q[4];
            first_full_d = full;
            phase_d      = PH_SECOND;
            state_d      = S_IDLE;
          end else begin
            pair_idx_d  = idx;
            pair_bad_d  = first_bad_q | key_q[4];
            pair_full_d = first_full_q | full;
            phase_d     = PH_WAIT;
            state_d     = S_EMIT;
          end
        end else begin
          scan_d = scan_q + SW'(1);
        end
      end
      S_EMIT: begin
        if (can_load) begin
          load               = 1'b1;
          out_d.out_byte     = {1'b0, first_idx_q, 3'b000} + {4'b0000, pair_idx_q} + offset_q;
          out_d.out_kind     = 1'b0;
          out_d.last         = 1'b1;
          out_d.bad_digit    = pair_bad_q;
          out_d.palette_full = pair_full_q;
          out_d.colours_used = 5'(pal_count);
          state_d            = S_IDLE;
        end
      end
      S_DUMP: begin
        if (can_load) begin
          load               = 1'b1;
          out_d.out_byte     = offset_q + dump_add;
          out_d.out_kind     = 1'b1;
          out_d.last         = (scan_q == SW'(DUMP_ENTRIES - 1));
          out_d.bad_digit    = rd_key[4];
          out_d.palette_full = 1'b0;
          out_d.colours_used = 5'(pal_count);
          if (scan_q == SW'(DUMP_ENTRIES - 1)) begin
            state_d = S_IDLE;
          end else begin
            scan_d = scan_q + SW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output beat register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_WAIT;
      first_idx_q  <= '0;
      first_bad_q  <= 1'b0;
      first_full_q <= 1'b0;
      out_valid_q  <= 1'b0;
      scan_q       <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      first_idx_q  <= first_idx_d;
      first_bad_q  <= first_bad_d;
      first_full_q <= first_full_d;
      out_valid_q  <= out_valid_d;
      scan_q       <= scan_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    pair_idx_q  <= pair_idx_d;
    pair_bad_q  <= pair_bad_d;
    pair_full_q <= pair_full_d;
    out_q       <= out_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= pipe_pkg::MARKER_RESET;
      offset_q <= pipe_pkg::OFFSET_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pipe_pkg::REG_MARKER: marker_q <= cfg_data_i;
        pipe_pkg::REG_OFFSET: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  `PIPE_ASSERT_SAME(a_count_bound, 1'b1, pal_count <= CNT_W'(PALETTE_SIZE), "palette count over size")
  `PIPE_ASSERT_NEXT(a_count_mono, 1'b1, pal_count >= $past(pal_count), "palette count went down")
  `PIPE_ASSERT_NEXT(a_dump_start, in_fire && in_i.mode, state_q == S_DUMP, "dump did not start")
  `PIPE_ASSERT_SAME(a_pair_last, out_valid_o && !out_o.out_kind, out_o.last, "pair beat not last")

endmodule

>>> tb/palette_index_pair_encoder_core_test.sv
// self-checking testbench for the palette index pair encoder core
`timescale 1ns / 1ps

module palette_index_pair_encoder_core_test;
  import pipe_pkg::*;

  localparam int unsigned PAL_SIZE    = PALETTE_SIZE_DEF;
  localparam int unsigned DUMP_COUNT  = DUMP_ENTRIES_DEF;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam int unsigned QUIET_LIMIT = 1000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND
  } pair_phase_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_beat   = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b1;
  out_item_t            out_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MARKER;
  logic [7:0]           cfg_data  = 8'd0;

  // stimulus and expectations
  in_item_t  char_queue[$];
  out_item_t expected_beats[$];

  // encoder mirror
  logic [7:0]  marker_reg = MARKER_RESET;
  logic [7:0]  offset_reg = OFFSET_RESET;
  pair_phase_e pair_phase = PH_IDLE;
  logic [3:0]  first_idx  = 4'd0;
  logic        first_bad  = 1'b0;
  logic        first_full = 1'b0;
  logic [4:0]  pal_keys[16];
  logic [4:0]  pal_count  = 5'd0;

  // pacing and bookkeeping
  int tx_pace = 1;
  int rx_pace = 1;
  int tx_wait = 0;
  int rx_wait = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int pairs_seen = 0;
  int dumps_seen = 0;
  int full_pairs = 0;
  int bad_pairs = 0;

  palette_index_pair_encoder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (in_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < 16; i++) pal_keys[i] = 5'd0;
  end

  function automatic int draw_wait(int pace);
    if (pace == 0) return 0;
    if (pace == 1 && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // hex character to colour key, 16 for anything else
  function automatic logic [4:0] hex_key(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return KEY_INVALID;
  endfunction

  // palette search in first-seen order, appending new keys while there is room
  function automatic logic [3:0] find_colour(input logic [4:0] key, output logic full);
    logic [3:0] idx;
    full = 1'b0;
    for (int i = 0; i < pal_count; i++) begin
      if (pal_keys[i] == key) return 4'(i);
    end
    if (pal_count >= PAL_SIZE) begin
      full = 1'b1;
      return 4'(PAL_SIZE - 1);
    end
    idx = pal_count[3:0];
    pal_keys[idx] = key;
    pal_count = pal_count + 5'd1;
    return idx;
  endfunction

  // expected beats for one accepted input beat
  function automatic void encode_char(in_item_t it);
    out_item_t  r;
    logic [4:0] key;
    logic [3:0] idx;
    logic       full;
    beats_sent++;
    if (it.mode) begin
      dumps_seen++;
      for (int k = 0; k < DUMP_COUNT; k++) begin
        key = pal_keys[k];
        r.out_byte     = (key == KEY_INVALID) ? offset_reg - 8'd1 : {3'b000, key} + offset_reg;
        r.out_kind     = 1'b1;
        r.last         = (k == DUMP_COUNT - 1);
        r.bad_digit    = (key == KEY_INVALID);
        r.palette_full = 1'b0;
        r.colours_used = pal_count;
        expected_beats.push_back(r);
      end
      return;
    end
    case (pair_phase)
      PH_FIRST: begin
        key        = hex_key(it.char_in);
        first_idx  = find_colour(key, full);
        first_bad  = (key == KEY_INVALID);
        first_full = full;
        pair_phase = PH_SECOND;
      end
      PH_SECOND: begin
        key = hex_key(it.char_in);
        idx = find_colour(key, full);
        r.out_byte     = {1'b0, first_idx, 3'b000} + {4'b0000, idx} + offset_reg;
        r.out_kind     = 1'b0;
        r.last         = 1'b1;
        r.bad_digit    = first_bad || (key == KEY_INVALID);
        r.palette_full = first_full || full;
        r.colours_used = pal_count;
        expected_beats.push_back(r);
        pairs_seen++;
        if (r.palette_full) full_pairs++;
        if (r.bad_digit) bad_pairs++;
        pair_phase = PH_IDLE;
      end
      default: begin
        pair_phase = (it.char_in == marker_reg) ? PH_FIRST : PH_IDLE;
      end
    endcase
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    mismatches++;
    $display("beat %0d: %s got %0d want %0d", beats_checked, what, got, want);
  endtask

  task automatic check_beat(out_item_t got);
    out_item_t want;
    if (expected_beats.size() == 0) begin
      note_mismatch("unexpected beat, out_byte", got.out_byte, 0);
      return;
    end
    want = expected_beats.pop_front();
    if (got.out_byte !== want.out_byte) note_mismatch("out_byte", got.out_byte, want.out_byte);
    if (got.out_kind !== want.out_kind) note_mismatch("out_kind", got.out_kind, want.out_kind);
    if (got.last !== want.last) note_mismatch("last", got.last, want.last);
    if (got.bad_digit !== want.bad_digit)
      note_mismatch("bad_digit", got.bad_digit, want.bad_digit);
    if (got.palette_full !== want.palette_full)
      note_mismatch("palette_full", got.palette_full, want.palette_full);
    if (got.colours_used !== want.colours_used)
      note_mismatch("colours_used", got.colours_used, want.colours_used);
    beats_checked++;
  endtask

  // input driver, fed from char_queue
  always @(posedge clk_i or negedge rst_n) begin : tx_side
    int   g;
    logic launch;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      launch = 1'b0;
      if (in_valid && in_ready_o) begin
        encode_char(in_beat);
        g = draw_wait(tx_pace);
        if (g == 0) launch = 1'b1;
        else tx_wait <= g;
      end else if (!in_valid) begin
        if (tx_wait != 0) tx_wait <= tx_wait - 1;
        else launch = 1'b1;
      end
      if (launch && char_queue.size() != 0) begin
        in_beat  <= char_queue.pop_front();
        in_valid <= 1'b1;
      end else if (in_valid && in_ready_o) begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_n) begin : rx_side
    int g;
    if (!rst_n) begin
      out_ready <= 1'b1;
      rx_wait   <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        check_beat(out_o);
        g = draw_wait(rx_pace);
        out_ready <= (g == 0);
        rx_wait   <= g;
      end else if (!out_ready) begin
        if (rx_wait > 1) begin
          rx_wait <= rx_wait - 1;
        end else begin
          out_ready <= 1'b1;
          rx_wait   <= 0;
        end
      end
    end
  end

  // cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("stalled for %0d cycles with %0d beats outstanding",
             quiet_cycles, expected_beats.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void push_char(logic [7:0] c);
    char_queue.push_back(in_item_t'{mode: 1'b0, char_in: c});
  endfunction

  function automatic void push_dump();
    char_queue.push_back(in_item_t'{mode: 1'b1, char_in: 8'($urandom_range(0, 255))});
  endfunction

  function automatic void push_pair(logic [7:0] a, logic [7:0] b);
    push_char(marker_reg);
    push_char(a);
    push_char(b);
  endfunction

  // mostly hex digits in all cases, sometimes any byte at all
  function automatic logic [7:0] pick_digit();
    case ($urandom_range(0, 5))
      0, 1:    return 8'("0" + $urandom_range(0, 9));
      2:       return 8'("A" + $urandom_range(0, 5));
      3:       return 8'("a" + $urandom_range(0, 5));
      4:       return 8'($urandom_range(0, 255));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  // well-formed pairs with random content, plus dumps, noise and pairs with a dump between their digits
  function automatic void add_random(int count);
    int n;
    n = 0;
    while (n < count) begin
      case ($urandom_range(0, 9))
        0: begin
          push_dump();
          n += 1;
        end
        1: begin
          push_char(8'($urandom_range(0, 255)));
          n += 1;
        end
        2: begin
          push_char(marker_reg);
          push_char(pick_digit());
          push_dump();
          push_char(pick_digit());
          n += 4;
        end
        default: begin
          push_pair(pick_digit(), pick_digit());
          n += 3;
        end
      endcase
    end
  endfunction

  // hold until every queued beat went in and every result came back
  task automatic drain();
    while (char_queue.size() != 0 || in_valid || expected_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == REG_MARKER) marker_reg = val;
    else offset_reg = val;
  endtask

  task automatic random_phase(logic [7:0] marker, logic [7:0] offset);
    drain();
    write_reg(REG_MARKER, marker);
    write_reg(REG_OFFSET, offset);
    for (int b = 0; b < 2; b++) begin
      tx_pace = $urandom_range(0, 2);
      rx_pace = $urandom_range(0, 2);
      add_random(22);
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed part at reset register values
    push_char("x");
    push_dump();
    push_pair("0", "F");
    push_pair("a", "F");
    push_pair("g", "9");
    push_pair(marker_reg, marker_reg);
    push_char(marker_reg);
    push_char("1");
    push_dump();
    push_char("2");
    push_dump();
    push_char(8'hFF);
    push_char(8'h00);

    // extremes of both registers, no idling on the first batch
    drain();
    write_reg(REG_MARKER, 8'h00);
    write_reg(REG_OFFSET, 8'hFF);
    tx_pace = 0;
    rx_pace = 0;
    add_random(22);
    drain();
    tx_pace = 2;
    rx_pace = 2;
    add_random(22);

    random_phase(8'hFF, 8'h00);
    random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    drain();

    if (expected_beats.size() != 0)
      note_mismatch("beats never delivered", 0, expected_beats.size());
    $display("covered %0d input beats: %0d pairs, %0d dumps, %0d result beats checked",
             beats_sent, pairs_seen, dumps_seen, beats_checked);
    $display("palette holds %0d colours; %0d pairs hit a full palette, %0d had bad digits",
             pal_count, full_pairs, bad_pairs);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
